[rtl/core/qss_pkg.sv]
// Shared constants, types and helpers for the sample quartile summary block.
package qss_pkg;

  localparam int MAX_SAMPLES  = 256;
  localparam int SAMPLE_WIDTH = 32;
  localparam int CNT_W        = $clog2(MAX_SAMPLES + 1);
  localparam int IDX_W        = $clog2(MAX_SAMPLES);
  localparam int POS_W        = IDX_W + 2;
  localparam int QTR_W        = SAMPLE_WIDTH + 2;
  localparam int CFG_W        = 9;

  // register map (word index)
  localparam int REG_MIN_SAMPLES = 0;

  // reason codes
  localparam logic REASON_NONE = 1'b0;
  localparam logic REASON_FEW  = 1'b1;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [QTR_W-1:0]        qtr_t;
  typedef logic [CNT_W-1:0]               cnt_t;
  typedef logic [IDX_W-1:0]               idx_t;

  typedef struct packed {
    logic load;
    logic drain;
  } chain_ctl_t;

  typedef struct packed {
    logic [2:0][IDX_W-1:0] lo;
    logic [2:0][IDX_W-1:0] hi;
    logic [2:0][1:0]       frac;
    idx_t                  last;
  } pick_pos_t;

  typedef struct packed {
    logic capture;
    logic calc;
    idx_t k;
  } collect_ctl_t;

  // a*4 + (b-a)*frac, frac in quarters
  function automatic qtr_t quarter_mix(input sample_t a, input sample_t b,
                                       input logic [1:0] frac);
    logic signed [SAMPLE_WIDTH+3:0] ax;
    logic signed [SAMPLE_WIDTH+3:0] bx;
    logic signed [SAMPLE_WIDTH+3:0] d;
    logic signed [SAMPLE_WIDTH+3:0] p;
    logic signed [SAMPLE_WIDTH+3:0] s;
    ax = {{4{a[SAMPLE_WIDTH-1]}}, a};
    bx = {{4{b[SAMPLE_WIDTH-1]}}, b};
    d  = bx - ax;
    p  = (frac[0] ? d : '0) + (frac[1] ? (d <<< 1) : '0);
    s  = (ax <<< 2) + p;
    return s[QTR_W-1:0];
  endfunction

endpackage

[rtl/core/qss_cell.sv]
// One insertion-sort cell: holds one sample, inserts or shifts toward the head.
module qss_cell (
  input  logic               clk,
  input  qss_pkg::chain_ctl_t ctl,
  input  logic               occ,
  input  qss_pkg::sample_t   sample,
  input  qss_pkg::sample_t   left_val,
  input  logic               left_shift,
  input  qss_pkg::sample_t   right_val,
  output qss_pkg::sample_t   val,
  output logic               shift
);
  import qss_pkg::*;

  sample_t val_r;
  sample_t val_nxt;

  // empty cells act as +infinity
  assign shift = !occ || (val_r > sample);
  assign val   = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctl.drain) begin
      val_nxt = right_val;
    end else if (ctl.load && shift) begin
      val_nxt = left_shift ? left_val : sample;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

[rtl/core/qss_chain.sv]
// Row of sort cells; head of the row is the smallest kept sample.
module qss_chain (
  input  logic                clk,
  input  qss_pkg::chain_ctl_t ctl,
  input  qss_pkg::sample_t    sample,
  input  qss_pkg::cnt_t       count,
  output qss_pkg::sample_t    head
);
  import qss_pkg::*;

  sample_t val      [MAX_SAMPLES];
  logic    shift    [MAX_SAMPLES];
  sample_t left_val [MAX_SAMPLES];
  logic    left_sh  [MAX_SAMPLES];
  sample_t right_val[MAX_SAMPLES];
  logic    occ      [MAX_SAMPLES];

  for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
    assign occ[i] = count > CNT_W'(i);

    if (i == 0) begin : g_first
      assign left_val[i] = sample;
      assign left_sh[i]  = 1'b0;
    end else begin : g_mid
      assign left_val[i] = val[i-1];
      assign left_sh[i]  = shift[i-1];
    end

    if (i == MAX_SAMPLES - 1) begin : g_last
      assign right_val[i] = val[i];
    end else begin : g_inner
      assign right_val[i] = val[i+1];
    end

    qss_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occ       (occ[i]),
      .sample    (sample),
      .left_val  (left_val[i]),
      .left_shift(left_sh[i]),
      .right_val (right_val[i]),
      .val       (val[i]),
      .shift     (shift[i])
    );
  end

  assign head = val[0];

endmodule

[rtl/core/qss_collect.sv]
// Picks order statistics off the draining row and forms the quartiles.
module qss_collect (
  input  logic                  clk,
  input  qss_pkg::collect_ctl_t ctl,
  input  qss_pkg::pick_pos_t    pos,
  input  qss_pkg::sample_t      head,
  output qss_pkg::sample_t      min_val,
  output qss_pkg::sample_t      max_val,
  output qss_pkg::qtr_t         q1,
  output qss_pkg::qtr_t         q2,
  output qss_pkg::qtr_t         q3
);
  import qss_pkg::*;

  sample_t       min_r;
  sample_t       max_r;
  sample_t [2:0] a_r;
  sample_t [2:0] b_r;
  qtr_t    [2:0] q_r;

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      if (ctl.k == '0) begin
        min_r <= head;
      end
      if (ctl.k == pos.last) begin
        max_r <= head;
      end
      for (int j = 0; j < 3; j++) begin
        if (ctl.k == pos.lo[j]) begin
          a_r[j] <= head;
        end
        if (ctl.k == pos.hi[j]) begin
          b_r[j] <= head;
        end
      end
    end
    if (ctl.calc) begin
      for (int j = 0; j < 3; j++) begin
        q_r[j] <= quarter_mix(a_r[j], b_r[j], pos.frac[j]);
      end
    end
  end

  assign min_val = min_r;
  assign max_val = max_r;
  assign q1      = q_r[0];
  assign q2      = q_r[1];
  assign q3      = q_r[2];

endmodule

[rtl/core/sample_quartile_summary_top.sv]
// Top level of the sample quartile summary: control, register port, result word.

// Sample quartile summary. Feed a run of signed Q16.16 samples with start;
// one sample word is taken per cycle while busy is low, and non-finite samples
// are dropped. Kept samples are insertion-sorted into a row of 256 cells as
// they arrive. Once 256 are held, further finite samples are dropped and
// flagged in capacity_overflow. The word carrying last_sample ends the run:
// busy then stays high through setup, while the row drains its n kept
// samples through the head cell (one per cycle), and through the quartile
// calculation and emit; with too few kept samples it stays high for setup only.
// The result word is marked by out_valid for exactly one cycle, in the same
// cycle as busy falls. The receiver cannot stall: capture it when
// out_valid is high. Quartiles and spread are in Q16.18 (quarter-LSB steps).
// minimum_samples (byte address 0) should only be written while busy is low.
module sample_quartile_summary_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // sample words
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [qss_pkg::SAMPLE_WIDTH-1:0] in_sample_value,
  input  logic                                 in_sample_finite,
  input  logic                                 in_last_sample,
  // result words
  output logic                                 out_valid,
  output logic                                 out_available,
  output logic                                 out_reason_code,
  output logic [qss_pkg::CNT_W-1:0]            out_kept_count,
  output logic signed [qss_pkg::SAMPLE_WIDTH-1:0] out_minimum_value,
  output logic signed [qss_pkg::QTR_W-1:0]     out_lower_quartile,
  output logic signed [qss_pkg::QTR_W-1:0]     out_median_value,
  output logic signed [qss_pkg::QTR_W-1:0]     out_upper_quartile,
  output logic signed [qss_pkg::SAMPLE_WIDTH-1:0] out_maximum_value,
  output logic [qss_pkg::QTR_W-1:0]            out_quartile_spread,
  output logic                                 out_capacity_overflow,
  // register port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [1:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);
  import qss_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_CALC  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]       state_r, state_nxt;
  cnt_t             count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  logic [CFG_W-1:0] min_samp_r;
  pick_pos_t        pos_r, pos_nxt;
  idx_t             k_r, k_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             fill_few, fill_sum;

  chain_ctl_t       chain_ctl;
  collect_ctl_t     coll_ctl;
  sample_t          head;
  sample_t          c_min, c_max;
  qtr_t             c_q1, c_q2, c_q3;

  logic             accept;
  logic             room;
  logic             too_few;
  logic [CFG_W-1:0] need;
  idx_t             nm1;
  logic [POS_W-1:0] p4 [3];
  logic             cfg_wr;

  assign busy   = state_r != S_IDLE;
  assign accept = start && !busy;
  assign room   = count_r < CNT_W'(MAX_SAMPLES);

  // a minimum of zero counts as one
  assign need    = (min_samp_r == '0) ? CFG_W'(1) : min_samp_r;
  assign too_few = int'(count_r) < int'(need);

  // quantile positions in quarters: q * (n - 1)
  assign nm1   = count_r[IDX_W-1:0] - IDX_W'(1);
  assign p4[0] = POS_W'(nm1);
  assign p4[1] = POS_W'(nm1) << 1;
  assign p4[2] = POS_W'(nm1) + (POS_W'(nm1) << 1);

  // register port: single register, writes land at any address
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (32'(paddr >> 2) == 32'(REG_MIN_SAMPLES)) ? 32'(min_samp_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_samp_r <= CFG_W'(1);
    end else if (cfg_wr) begin
      min_samp_r <= pwdata[CFG_W-1:0];
    end
  end

  assign chain_ctl.load  = accept && in_sample_finite && room;
  assign chain_ctl.drain = state_r == S_DRAIN;

  assign coll_ctl.capture = state_r == S_DRAIN;
  assign coll_ctl.calc    = state_r == S_CALC;
  assign coll_ctl.k       = k_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    pos_nxt       = pos_r;
    k_nxt         = k_r;
    out_valid_nxt = 1'b0;
    fill_few      = 1'b0;
    fill_sum      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_sample_finite) begin
            if (room) begin
              count_nxt = count_r + CNT_W'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end
          if (in_last_sample) begin
            state_nxt = S_SETUP;
          end
        end
      end
      S_SETUP: begin
        if (too_few) begin
          fill_few      = 1'b1;
          out_valid_nxt = 1'b1;
          count_nxt     = '0;
          ovf_nxt       = 1'b0;
          state_nxt     = S_IDLE;
        end else begin
          for (int j = 0; j < 3; j++) begin
            pos_nxt.lo[j]   = p4[j][POS_W-1:2];
            pos_nxt.frac[j] = p4[j][1:0];
            pos_nxt.hi[j]   = p4[j][POS_W-1:2] + IDX_W'(p4[j][1:0] != 2'b00);
          end
          pos_nxt.last = nm1;
          k_nxt        = '0;
          state_nxt    = S_DRAIN;
        end
      end
      S_DRAIN: begin
        k_nxt = k_r + IDX_W'(1);
        if (k_r == pos_r.last) begin
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        fill_sum      = 1'b1;
        out_valid_nxt = 1'b1;
        count_nxt     = '0;
        ovf_nxt       = 1'b0;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
  end

  // result word; held between strobes
  always_ff @(posedge clk) begin
    if (fill_few) begin
      out_available         <= 1'b0;
      out_reason_code       <= REASON_FEW;
      out_kept_count        <= count_r;
      out_capacity_overflow <= ovf_r;
      out_minimum_value     <= '0;
      out_lower_quartile    <= '0;
      out_median_value      <= '0;
      out_upper_quartile    <= '0;
      out_maximum_value     <= '0;
      out_quartile_spread   <= '0;
    end else if (fill_sum) begin
      out_available         <= 1'b1;
      out_reason_code       <= REASON_NONE;
      out_kept_count        <= count_r;
      out_capacity_overflow <= ovf_r;
      out_minimum_value     <= c_min;
      out_lower_quartile    <= c_q1;
      out_median_value      <= c_q2;
      out_upper_quartile    <= c_q3;
      out_maximum_value     <= c_max;
      out_quartile_spread   <= QTR_W'(c_q3 - c_q1);
    end
  end

  assign out_valid = out_valid_r;

  qss_chain u_chain (
    .clk   (clk),
    .ctl   (chain_ctl),
    .sample(in_sample_value),
    .count (count_r),
    .head  (head)
  );

  qss_collect u_collect (
    .clk    (clk),
    .ctl    (coll_ctl),
    .pos    (pos_r),
    .head   (head),
    .min_val(c_min),
    .max_val(c_max),
    .q1     (c_q1),
    .q2     (c_q2),
    .q3     (c_q3)
  );

endmodule

[dv/testbench.sv]
// Self-checking testbench for the sample quartile summary top level.
module testbench;
  import qss_pkg::*;

  // Clock is 4 time units; reset is held low at the start.
  localparam int CLK_HALF      = 2;
  localparam int RESET_CYCLES  = 5;
  // Generous limit for the whole test: ~1.5k words, idle gaps between bursts,
  // and a drain at the end of each run.
  localparam int CYCLE_LIMIT   = 300000;
  localparam int RANDOM_WORDS  = 1400;
  localparam int PHASES        = 6;
  // Once the last summary has come the block is idle, but give it a margin.
  localparam int SETTLE_CYCLES = 8;
  localparam int PRINT_CAP     = 100;

  // How random sample values are drawn for one run.
  typedef enum int {
    VAL_WIDE,    // any 32-bit value
    VAL_NARROW,  // small integers, lots of repeats
    VAL_CORNER   // full-scale, zero, +/-1, mixed with random
  } value_style_t;

  // One sample word as presented on the in_ ports.
  typedef struct {
    sample_t value;
    logic    finite;
    logic    last;
  } sample_word_t;

  // One summary word as seen on the out_ ports.
  typedef struct {
    logic             available;
    logic             reason;
    cnt_t             kept;
    sample_t          min_v;
    qtr_t             q1;
    qtr_t             q2;
    qtr_t             q3;
    sample_t          max_v;
    logic [QTR_W-1:0] spread;
    logic             overflow;
  } summary_t;

  logic                   clk;
  logic                   rst_n;
  logic                   start;
  logic                   busy;
  sample_t                in_sample_value;
  logic                   in_sample_finite;
  logic                   in_last_sample;
  logic                   out_valid;
  logic                   out_available;
  logic                   out_reason_code;
  cnt_t                   out_kept_count;
  sample_t                out_minimum_value;
  qtr_t                   out_lower_quartile;
  qtr_t                   out_median_value;
  qtr_t                   out_upper_quartile;
  sample_t                out_maximum_value;
  logic [QTR_W-1:0]       out_quartile_spread;
  logic                   out_capacity_overflow;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [1:0]             paddr;
  logic [31:0]            pwdata;
  logic [31:0]            prdata;
  logic                   pready;

  sample_quartile_summary_top dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_sample_value       (in_sample_value),
    .in_sample_finite      (in_sample_finite),
    .in_last_sample        (in_last_sample),
    .out_valid             (out_valid),
    .out_available         (out_available),
    .out_reason_code       (out_reason_code),
    .out_kept_count        (out_kept_count),
    .out_minimum_value     (out_minimum_value),
    .out_lower_quartile    (out_lower_quartile),
    .out_median_value      (out_median_value),
    .out_upper_quartile    (out_upper_quartile),
    .out_maximum_value     (out_maximum_value),
    .out_quartile_spread   (out_quartile_spread),
    .out_capacity_overflow (out_capacity_overflow),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Words waiting for the driver, and summaries waiting for the monitor.
  sample_word_t pending_words[$];
  summary_t     expected_summaries[$];

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned words_queued = 0;

  // Shadow of the block: the sorted run, its count, the overflow flag and the
  // minimum_samples register.
  sample_t          run_sorted[MAX_SAMPLES];
  int unsigned      run_count = 0;
  logic             run_overflow = 1'b0;
  logic [CFG_W-1:0] min_kept_cfg = CFG_W'(1);

  // Driver burst state: words left in this burst, idle cycles left in the gap.
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    error_count++;
    if (error_count <= PRINT_CAP) begin
      $display("MISMATCH %s: got %h want %h (cycle %0d)", what, got, want, cycle_count);
    end
  endtask

  // Quantile at quarters/4 of (n-1), scaled by 4 so quarter steps are exact.
  function automatic longint quarter_point(int unsigned quarters, int unsigned n);
    int unsigned p4;
    int unsigned lo;
    int unsigned hi;
    longint      frac;
    longint      a;
    longint      b;
    p4   = quarters * (n - 1);
    lo   = p4 >> 2;
    frac = longint'(p4 & 3);
    hi   = (frac != 0) ? lo + 1 : lo;
    a    = longint'(run_sorted[lo]);
    b    = longint'(run_sorted[hi]);
    return a * 4 + (b - a) * frac;
  endfunction

  // Fold one accepted word into the shadow run; a last word closes the run
  // and queues the summary it should produce.
  function automatic void absorb_word(sample_word_t w);
    int unsigned pos;
    int unsigned need;
    summary_t    s;
    longint      q1;
    longint      q2;
    longint      q3;
    longint      iqr;
    if (w.finite) begin
      if (run_count < MAX_SAMPLES) begin
        pos = run_count;
        while (pos > 0 && run_sorted[pos-1] > w.value) begin
          run_sorted[pos] = run_sorted[pos-1];
          pos--;
        end
        run_sorted[pos] = w.value;
        run_count++;
      end else begin
        // store full: finite sample dropped and flagged
        run_overflow = 1'b1;
      end
    end
    if (w.last) begin
      s = '{default: '0};
      // a minimum_samples of zero still needs one sample
      need = (min_kept_cfg == '0) ? 32'd1 : 32'(min_kept_cfg);
      s.kept     = run_count[CNT_W-1:0];
      s.overflow = run_overflow;
      if (run_count < need) begin
        s.available = 1'b0;
        s.reason    = REASON_FEW;
      end else begin
        q1  = quarter_point(1, run_count);
        q2  = quarter_point(2, run_count);
        q3  = quarter_point(3, run_count);
        iqr = q3 - q1;
        s.available = 1'b1;
        s.reason    = REASON_NONE;
        s.min_v     = run_sorted[0];
        s.max_v     = run_sorted[run_count-1];
        s.q1        = q1[QTR_W-1:0];
        s.q2        = q2[QTR_W-1:0];
        s.q3        = q3[QTR_W-1:0];
        s.spread    = iqr[QTR_W-1:0];
      end
      expected_summaries.push_back(s);
      run_count    = 0;
      run_overflow = 1'b0;
    end
  endfunction

  function automatic sample_t pick_value(value_style_t style);
    case (style)
      VAL_NARROW: return sample_t'((int'($urandom_range(0, 16)) - 8) * 65536);
      VAL_CORNER: begin
        case ($urandom_range(0, 5))
          0: return 32'sh8000_0000;
          1: return 32'sh7FFF_FFFF;
          2: return 32'sh0000_0000;
          3: return -32'sd1;
          4: return 32'sd1;
          default: return sample_t'($urandom);
        endcase
      end
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic void queue_word(sample_t v, logic finite, logic last);
    pending_words.push_back('{v, finite, last});
    words_queued++;
  endfunction

  // One run of len words, the last one marked; about 1 in drop_odds words
  // is non-finite (0 keeps them all finite).
  function automatic void queue_run(int unsigned len, value_style_t style,
                                    int unsigned drop_odds);
    logic finite;
    for (int unsigned i = 0; i < len; i++) begin
      finite = (drop_odds == 0) ? 1'b1 : ($urandom_range(1, drop_odds) != 1);
      queue_word(pick_value(style), finite, i == len - 1);
    end
  endfunction

  // Block until every queued word went in and every summary came out.
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_words.size() != 0 || start || busy || expected_summaries.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write (setup + access), then read it straight back.
  task automatic write_min_samples(input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 2'(REG_MIN_SAMPLES * 4);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    min_kept_cfg = value[CFG_W-1:0];
    // back-to-back read setup; psel stays high
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    if (prdata !== {{(32-CFG_W){1'b0}}, min_kept_cfg}) begin
      report_mismatch("minimum_samples readback", 64'(prdata), 64'(min_kept_cfg));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Driver. A word is taken at an edge with start high and busy low. Start
  // stays high across back-to-back words, so it gets at most one assignment
  // per edge. Bursts of 1..24 words, then an idle gap that is nonzero a third
  // of the time, so there are stretches with no idling at all.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        absorb_word(pending_words.pop_front());
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_words.size() > 0) begin
          start            <= 1'b1;
          in_sample_value  <= pending_words[0].value;
          in_sample_finite <= pending_words[0].finite;
          in_last_sample   <= pending_words[0].last;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 9) : 0;
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor. out_valid marks a one-cycle summary word; the receiver has no
  // way to stall, so every marked cycle is checked against the oldest
  // expectation.
  always @(posedge clk) begin
    summary_t got;
    summary_t want;
    if (rst_n && out_valid) begin
      got = '{out_available, out_reason_code, out_kept_count, out_minimum_value,
              out_lower_quartile, out_median_value, out_upper_quartile,
              out_maximum_value, out_quartile_spread, out_capacity_overflow};
      if (expected_summaries.size() == 0) begin
        report_mismatch("summary word with none expected", 64'(0), 64'(0));
      end else begin
        want = expected_summaries.pop_front();
        if (got.available !== want.available)
          report_mismatch("available", 64'(got.available), 64'(want.available));
        if (got.reason !== want.reason)
          report_mismatch("reason_code", 64'(got.reason), 64'(want.reason));
        if (got.kept !== want.kept)
          report_mismatch("kept_count", 64'(got.kept), 64'(want.kept));
        if (got.min_v !== want.min_v)
          report_mismatch("minimum_value", 64'(got.min_v), 64'(want.min_v));
        if (got.q1 !== want.q1)
          report_mismatch("lower_quartile", 64'(got.q1), 64'(want.q1));
        if (got.q2 !== want.q2)
          report_mismatch("median_value", 64'(got.q2), 64'(want.q2));
        if (got.q3 !== want.q3)
          report_mismatch("upper_quartile", 64'(got.q3), 64'(want.q3));
        if (got.max_v !== want.max_v)
          report_mismatch("maximum_value", 64'(got.max_v), 64'(want.max_v));
        if (got.spread !== want.spread)
          report_mismatch("quartile_spread", 64'(got.spread), 64'(want.spread));
        if (got.overflow !== want.overflow)
          report_mismatch("capacity_overflow", 64'(got.overflow), 64'(want.overflow));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int unsigned  phase_min[PHASES];
    int unsigned  phase_quota;
    int unsigned  phase_start;
    int unsigned  run_len;
    int unsigned  drop_odds;
    logic [31:0]  cfg_word;
    value_style_t style;

    start            <= 1'b0;
    in_sample_value  <= '0;
    in_sample_finite <= 1'b0;
    in_last_sample   <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    rst_n            <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part, minimum_samples at its reset value of 1 ----
    // single full-scale samples: every quartile equals the sample
    queue_word(32'sh7FFF_FFFF, 1'b1, 1'b1);
    queue_word(32'sh8000_0000, 1'b1, 1'b1);
    // run with nothing kept: too few samples, last word non-finite
    queue_word(sample_t'($urandom), 1'b0, 1'b1);
    // both extremes: widest quartile steps and the largest spread
    queue_word(32'sh8000_0000, 1'b1, 1'b0);
    queue_word(32'sh7FFF_FFFF, 1'b1, 1'b1);
    // descending input, a dropped word mid-run, and a non-finite last word
    queue_word(32'sh0003_0000, 1'b1, 1'b0);
    queue_word(32'sh0002_4000, 1'b1, 1'b0);
    queue_word(32'sh7000_0000, 1'b0, 1'b0);
    queue_word(-32'sh0001_0000, 1'b1, 1'b0);
    queue_word(32'sh1234_5678, 1'b0, 1'b1);
    // repeated values
    queue_word(32'sh0005_0000, 1'b1, 1'b0);
    queue_word(32'sh0005_0000, 1'b1, 1'b0);
    queue_word(-32'sh0005_0000, 1'b1, 1'b0);
    queue_word(32'sh0005_0000, 1'b1, 1'b1);
    wait_idle();

    // minimum_samples of 0 behaves like 1
    write_min_samples(32'd0);
    queue_word(sample_t'($urandom), 1'b0, 1'b1);
    queue_word(sample_t'($urandom), 1'b1, 1'b1);
    wait_idle();

    // threshold of 256: a short run cannot meet it
    write_min_samples(32'd256);
    queue_run(3, VAL_CORNER, 0);
    wait_idle();

    // ---- random part: one register setting per phase ----
    phase_min[0] = 256;
    phase_min[1] = 1;
    phase_min[2] = 0;
    phase_min[3] = $urandom_range(2, 16);
    phase_min[4] = $urandom_range(0, 256);
    phase_min[5] = 255;
    phase_quota  = RANDOM_WORDS / PHASES;

    for (int p = 0; p < PHASES; p++) begin
      // odd phases put junk above the 9-bit field; it must be ignored
      cfg_word = phase_min[p];
      if (p % 2 == 1) cfg_word[31:CFG_W] = (32-CFG_W)'($urandom);
      write_min_samples(cfg_word);
      phase_start = words_queued;

      // a few long runs: exactly full, past full, and just at the threshold
      case (p)
        0: queue_run(256, VAL_WIDE, 0);
        3: queue_run(266, VAL_CORNER, 0);
        5: queue_run(255, VAL_NARROW, 0);
        default: ;
      endcase

      // mostly short well-formed runs with random content; some drop about half
      // their words, some keep nothing at all
      while (words_queued - phase_start < phase_quota) begin
        style = value_style_t'($urandom_range(0, 2));
        case ($urandom_range(0, 3))
          2: drop_odds = 5;
          3: drop_odds = 2;
          default: drop_odds = 0;
        endcase
        run_len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(1, 24);
        queue_run(run_len, style, drop_odds);
      end

      // sender holds off here until every summary of the phase is back
      wait_idle();
    end

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/qss_pkg.sv
rtl/core/qss_cell.sv
rtl/core/qss_chain.sv
rtl/core/qss_collect.sv
rtl/core/sample_quartile_summary_top.sv
dv/testbench.sv
